>>> sv/running_stat_normalizer_unit_defines.svh
// assertion macros shared by the normalizer rtl
`ifndef RUNNING_STAT_NORMALIZER_UNIT_DEFINES_SVH
`define RUNNING_STAT_NORMALIZER_UNIT_DEFINES_SVH

// same-cycle implication, disabled while in reset
`define RSN_ASSERT_IMPL(name, clk, rst_n, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, disabled while in reset
`define RSN_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> sv/rsn_pkg.sv
// shared constants, types and states of the running statistics normalizer
package rsn_pkg;
	localparam int DIMENSIONS = 64;
	localparam int ADDR_W = (DIMENSIONS > 1) ? $clog2(DIMENSIONS) : 1;
	localparam int DIM_W = 6;
	localparam int VAL_W = 32;
	localparam int VAR_W = 48;
	localparam int CNT_W = 32;
	localparam int ENTRY_W = VAL_W + VAR_W;
	localparam int DIV_NW = 49;
	localparam int DIV_DW = 32;
	localparam int DIV_CW = $clog2(DIV_NW + 1);
	localparam int SQ_RW = 32;
	localparam int SQ_CW = $clog2(SQ_RW + 1);
	localparam int MUL_W = 33;
	localparam int MUL_CW = $clog2(MUL_W + 1);
	localparam int CLAMP_Q = 524288;
	localparam int CFG_AW = 2;
	localparam logic [CFG_AW-1:0] ADDR_NORM_EN = 2'd0;
	localparam logic [VAR_W-1:0] VAR_RESET = 48'd65536;
	localparam logic [VAR_W-1:0] VAR_MAX = {VAR_W{1'b1}};
	localparam logic [CNT_W-1:0] COUNT_MAX = {CNT_W{1'b1}};

	typedef struct packed {
		logic busy;
		logic done;
	} rsn_stat_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_READ,
		ST_LOAD,
		ST_DIV_MEAN,
		ST_MUL,
		ST_DIV_VAR,
		ST_WRITE,
		ST_SQRT,
		ST_DIV_NORM,
		ST_DONE
	} rsn_state_t;
endpackage

>>> sv/rsn_sample_if.sv
// input channel: one observation element per item
interface rsn_sample_if;
	logic valid;
	logic ready;
	logic signed [rsn_pkg::VAL_W-1:0] sample_value;
	logic [rsn_pkg::DIM_W-1:0] dimension;
	logic update_stats;

	modport source(output valid, sample_value, dimension, update_stats, input ready);
	modport sink(input valid, sample_value, dimension, update_stats, output ready);
endinterface

>>> sv/rsn_result_if.sv
// output channel: one result item per input item
interface rsn_result_if;
	logic valid;
	logic ready;
	logic signed [rsn_pkg::VAL_W-1:0] result_value;
	logic was_normalized;

	modport source(output valid, result_value, was_normalized, input ready);
	modport sink(input valid, result_value, was_normalized, output ready);
endinterface

>>> sv/rsn_ram.sv
// generic single write port ram with registered read
module rsn_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end
endmodule

>>> sv/rsn_div.sv
// restoring divider, one quotient bit per cycle
module rsn_div (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [rsn_pkg::DIV_NW-1:0] num,
	input  logic [rsn_pkg::DIV_DW-1:0] den,
	output rsn_pkg::rsn_stat_t        stat,
	output logic [rsn_pkg::DIV_NW-1:0] quo
);
	import rsn_pkg::*;

	logic [DIV_NW-1:0] shf_q;
	logic [DIV_DW-1:0] rem_q;
	logic [DIV_DW-1:0] den_q;
	logic [DIV_CW-1:0] cnt_q;
	logic busy_q;
	logic done_q;
	logic [DIV_DW:0] trial;
	logic [DIV_DW+1:0] diff;
	logic ge;

	// trial subtract of the divisor from the shifted remainder
	assign trial = {rem_q, shf_q[DIV_NW-1]};
	assign diff = {1'b0, trial} - {2'b00, den_q};
	assign ge = !diff[DIV_DW+1];

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= DIV_CW'(DIV_NW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == DIV_CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// numerator shifts out as quotient bits shift in
	always_ff @(posedge clk) begin
		if (start) begin
			shf_q <= num;
			rem_q <= '0;
			den_q <= den;
		end else if (busy_q) begin
			rem_q <= ge ? diff[DIV_DW-1:0] : trial[DIV_DW-1:0];
			shf_q <= {shf_q[DIV_NW-2:0], ge};
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign quo = shf_q;
endmodule

>>> sv/rsn_sqrt.sv
// digit-by-digit integer square root, one root bit per cycle
module rsn_sqrt (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [2*rsn_pkg::SQ_RW-1:0] radicand,
	output rsn_pkg::rsn_stat_t          stat,
	output logic [rsn_pkg::SQ_RW-1:0]   root
);
	import rsn_pkg::*;

	logic [2*SQ_RW-1:0] rad_q;
	logic [SQ_RW-1:0] root_q;
	logic [SQ_RW+1:0] rem_q;
	logic [SQ_CW-1:0] cnt_q;
	logic busy_q;
	logic done_q;
	logic [SQ_RW+3:0] rem_sh;
	logic [SQ_RW+3:0] trial;
	logic [SQ_RW+4:0] diff;
	logic ge;

	// bring down two radicand bits, try root*4+1
	assign rem_sh = {rem_q, rad_q[2*SQ_RW-1:2*SQ_RW-2]};
	assign trial = {2'b00, root_q, 2'b01};
	assign diff = {1'b0, rem_sh} - {1'b0, trial};
	assign ge = !diff[SQ_RW+4];

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= SQ_CW'(SQ_RW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == SQ_CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (start) begin
			rad_q <= radicand;
			root_q <= '0;
			rem_q <= '0;
		end else if (busy_q) begin
			rad_q <= {rad_q[2*SQ_RW-3:0], 2'b00};
			rem_q <= ge ? diff[SQ_RW+1:0] : rem_sh[SQ_RW+1:0];
			root_q <= {root_q[SQ_RW-2:0], ge};
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign root = root_q;
endmodule

>>> sv/running_stat_normalizer_unit.sv
// running mean and variance normalizer, top level
// Usage: sample_ch carries one Q16.16 observation element with its dimension
// and an update flag; result_ch returns one item per input item holding the
// normalized value (clamped to +-8.0) or the raw sample, with was_normalized.
// The APB port holds normalize_enable at byte address 0; write it only while
// the block is idle. One item is in flight at a time: sample_ch.ready is high
// only when the sequencer is idle.
// Sequencing: a full update and normalize makes three passes through the
// shared bit-serial divider (mean, variance, normalize) and also uses the
// shift-add multiply and the square root unit; normalizing without update
// uses the square root unit and one divider pass.
// Statistics live in a 64-entry ram; per-entry valid flags make unwritten
// entries read as mean 0, variance 1.0.
// Reset: valid flags, sample count and control clear at once, normalize
// enable returns to 1; no clearing pass is needed.
// Stall: a finished result waits in the output register until taken; the
// next item is accepted meanwhile, its result waits in the done state.
module running_stat_normalizer_unit (
	input  logic                         clk,
	input  logic                         arst_n,
	rsn_sample_if.sink                   sample_ch,
	rsn_result_if.source                 result_ch,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [rsn_pkg::CFG_AW-1:0]   paddr,
	input  logic [31:0]                  pwdata,
	output logic [31:0]                  prdata,
	output logic                         pready
);
	import rsn_pkg::*;
	`include "running_stat_normalizer_unit_defines.svh"

	rsn_state_t state_q, state_d;

	logic en_cfg_q;
	logic en_q;
	logic upd_q;
	logic signed [VAL_W-1:0] x_q;
	logic [ADDR_W-1:0] dim_q;
	logic [CNT_W-1:0] count_q;
	logic signed [VAL_W-1:0] mean_q;
	logic [VAR_W-1:0] var_q;
	logic [DIMENSIONS-1:0] valid_q;
	logic rd_valid_q;
	logic delta_neg_q;
	logic [MUL_W-1:0] mag_a_q;
	logic [MUL_W:0] mul_acc_q;
	logic [MUL_W-1:0] mul_lo_q;
	logic [MUL_CW-1:0] mul_cnt_q;
	logic term_ge_q;
	logic num_neg_q;
	logic signed [VAL_W-1:0] res_val_q;
	logic res_norm_q;
	logic out_valid_q;
	logic signed [VAL_W-1:0] out_val_q;
	logic out_norm_q;

	logic accept;
	logic dim_ok;
	logic fold_go;
	logic norm_go;
	logic out_free;
	logic cfg_wr;

	logic ram_re;
	logic ram_we;
	logic [ENTRY_W-1:0] ram_rdata;

	logic div_start;
	logic [DIV_NW-1:0] div_num;
	logic [DIV_DW-1:0] div_den;
	rsn_stat_t div_stat;
	logic [DIV_NW-1:0] div_quo;

	logic sqrt_start;
	logic [2*SQ_RW-1:0] sqrt_rad;
	rsn_stat_t sqrt_stat;
	logic [SQ_RW-1:0] sqrt_root;

	logic signed [VAL_W:0] delta;
	logic [MUL_W-1:0] delta_mag;
	logic signed [VAL_W+1:0] mean_new;
	logic signed [VAL_W:0] after;
	logic [MUL_W-1:0] after_mag;
	logic [MUL_W:0] mul_sum;
	logic [2*MUL_W-1:0] product;
	logic [VAR_W-1:0] term;
	logic term_ge;
	logic [VAR_W-1:0] var_diff;
	logic [VAR_W:0] var_sum;
	logic [VAR_W-1:0] var_floor;
	logic [VAL_W-1:0] q_mag;

	// handshake
	assign accept = sample_ch.valid && sample_ch.ready;
	assign sample_ch.ready = (state_q == ST_IDLE);
	assign dim_ok = 32'(sample_ch.dimension) < DIMENSIONS;
	assign out_free = !out_valid_q || result_ch.ready;
	assign fold_go = en_q && upd_q && (count_q != '0);
	assign norm_go = en_q && (count_q > CNT_W'(1));

	// configuration register
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready && (paddr == ADDR_NORM_EN);
	assign prdata = (paddr == ADDR_NORM_EN) ? {31'b0, en_cfg_q} : 32'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			en_cfg_q <= 1'b1;
		end else if (cfg_wr) begin
			en_cfg_q <= pwdata[0];
		end
	end

	// datapath helpers
	assign delta = {x_q[VAL_W-1], x_q} - {mean_q[VAL_W-1], mean_q};
	assign delta_mag = delta[VAL_W] ? MUL_W'(-delta) : MUL_W'(delta);
	assign mean_new = {{2{mean_q[VAL_W-1]}}, mean_q}
		+ (delta_neg_q ? -{1'b0, div_quo[MUL_W-1:0]} : {1'b0, div_quo[MUL_W-1:0]});
	assign after = {x_q[VAL_W-1], x_q} - mean_new[VAL_W:0];
	assign after_mag = after[VAL_W] ? MUL_W'(-after) : MUL_W'(after);
	assign mul_sum = mul_acc_q + (mul_lo_q[0] ? {1'b0, mag_a_q} : '0);
	assign product = {mul_acc_q[MUL_W-1:0], mul_lo_q};
	assign term = product[VAR_W+15:16];
	assign term_ge = term >= var_q;
	assign var_diff = term_ge ? term - var_q : var_q - term;
	assign var_sum = term_ge_q ? {1'b0, var_q} + {1'b0, div_quo[VAR_W-1:0]}
		: {1'b0, var_q} - {1'b0, div_quo[VAR_W-1:0]};
	assign var_floor = (var_q == '0) ? VAR_W'(1) : var_q;
	assign sqrt_rad = {var_floor, 16'b0};
	assign q_mag = (div_quo > DIV_NW'(CLAMP_Q)) ? VAL_W'(CLAMP_Q) : div_quo[VAL_W-1:0];

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and unit strobes
	always_comb begin
		state_d = state_q;
		div_start = 1'b0;
		div_num = '0;
		div_den = '0;
		sqrt_start = 1'b0;
		ram_we = 1'b0;
		ram_re = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					ram_re = 1'b1;
					state_d = dim_ok ? ST_READ : ST_DONE;
				end
			end
			ST_READ: begin
				state_d = ST_LOAD;
			end
			ST_LOAD: begin
				if (fold_go) begin
					div_start = 1'b1;
					div_num = DIV_NW'(delta_mag);
					div_den = count_q;
					state_d = ST_DIV_MEAN;
				end else if (norm_go) begin
					sqrt_start = 1'b1;
					state_d = ST_SQRT;
				end else begin
					state_d = ST_DONE;
				end
			end
			ST_DIV_MEAN: begin
				if (div_stat.done) begin
					state_d = ST_MUL;
				end
			end
			ST_MUL: begin
				if (mul_cnt_q == MUL_CW'(MUL_W)) begin
					div_start = 1'b1;
					div_num = {1'b0, var_diff};
					div_den = count_q;
					state_d = ST_DIV_VAR;
				end
			end
			ST_DIV_VAR: begin
				if (div_stat.done) begin
					state_d = ST_WRITE;
				end
			end
			ST_WRITE: begin
				ram_we = 1'b1;
				if (norm_go) begin
					sqrt_start = 1'b1;
					state_d = ST_SQRT;
				end else begin
					state_d = ST_DONE;
				end
			end
			ST_SQRT: begin
				if (sqrt_stat.done) begin
					div_start = 1'b1;
					div_num = {delta_mag, 16'b0};
					div_den = sqrt_root;
					state_d = ST_DIV_NORM;
				end
			end
			ST_DIV_NORM: begin
				if (div_stat.done) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// sample count and entry valid flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			valid_q <= '0;
		end else begin
			if (accept && dim_ok && en_cfg_q && sample_ch.update_stats
				&& (sample_ch.dimension == '0) && (count_q != COUNT_MAX)) begin
				count_q <= count_q + 1'b1;
			end
			if (ram_we) begin
				valid_q[dim_q] <= 1'b1;
			end
		end
	end

	// item fields and statistics working registers
	always_ff @(posedge clk) begin
		if (accept) begin
			x_q <= sample_ch.sample_value;
			dim_q <= ADDR_W'(sample_ch.dimension);
			upd_q <= sample_ch.update_stats;
			en_q <= en_cfg_q;
			rd_valid_q <= valid_q[ADDR_W'(sample_ch.dimension)];
			res_val_q <= sample_ch.sample_value;
			res_norm_q <= 1'b0;
		end
		case (state_q)
			ST_READ: begin
				mean_q <= rd_valid_q ? ram_rdata[ENTRY_W-1:VAR_W] : '0;
				var_q <= rd_valid_q ? ram_rdata[VAR_W-1:0] : VAR_RESET;
			end
			ST_LOAD: begin
				delta_neg_q <= delta[VAL_W];
				mag_a_q <= delta_mag;
			end
			ST_DIV_MEAN: begin
				if (div_stat.done) begin
					mean_q <= mean_new[VAL_W-1:0];
					mul_acc_q <= '0;
					mul_lo_q <= after_mag;
					mul_cnt_q <= '0;
				end
			end
			ST_MUL: begin
				if (mul_cnt_q != MUL_CW'(MUL_W)) begin
					mul_acc_q <= {1'b0, mul_sum[MUL_W:1]};
					mul_lo_q <= {mul_sum[0], mul_lo_q[MUL_W-1:1]};
					mul_cnt_q <= mul_cnt_q + 1'b1;
				end else begin
					term_ge_q <= term_ge;
				end
			end
			ST_DIV_VAR: begin
				if (div_stat.done) begin
					var_q <= var_sum[VAR_W] ? VAR_MAX : var_sum[VAR_W-1:0];
				end
			end
			ST_SQRT: begin
				if (sqrt_stat.done) begin
					num_neg_q <= delta[VAL_W];
				end
			end
			ST_DIV_NORM: begin
				if (div_stat.done) begin
					res_val_q <= num_neg_q ? -q_mag : q_mag;
					res_norm_q <= 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_DONE && out_free) begin
			out_valid_q <= 1'b1;
		end else if (result_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_DONE && out_free) begin
			out_val_q <= res_val_q;
			out_norm_q <= res_norm_q;
		end
	end

	assign result_ch.valid = out_valid_q;
	assign result_ch.result_value = out_val_q;
	assign result_ch.was_normalized = out_norm_q;

	// statistics store: mean in the upper word, variance below
	rsn_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(DIMENSIONS)
	) u_stat_ram (
		.clk(clk),
		.we(ram_we),
		.waddr(dim_q),
		.wdata({mean_q, var_q}),
		.re(ram_re),
		.raddr(ADDR_W'(sample_ch.dimension)),
		.rdata(ram_rdata)
	);

	// shared divider
	rsn_div u_div (
		.clk(clk),
		.arst_n(arst_n),
		.start(div_start),
		.num(div_num),
		.den(div_den),
		.stat(div_stat),
		.quo(div_quo)
	);

	// square root of the floored variance
	rsn_sqrt u_sqrt (
		.clk(clk),
		.arst_n(arst_n),
		.start(sqrt_start),
		.radicand(sqrt_rad),
		.stat(sqrt_stat),
		.root(sqrt_root)
	);

	// checks
	`RSN_ASSERT_NEXT(a_accept_leaves_idle, clk, arst_n, accept, state_q != ST_IDLE, "accepted item did not start")
	`RSN_ASSERT_NEXT(a_count_monotonic, clk, arst_n, 1'b1, count_q >= $past(count_q), "sample count went down")
	`RSN_ASSERT_IMPL(a_norm_clamped, clk, arst_n, result_ch.valid && result_ch.was_normalized, (result_ch.result_value <= 32'sd524288) && (result_ch.result_value >= -32'sd524288), "normalized result outside clamp")
	`RSN_ASSERT_IMPL(a_div_start_idle, clk, arst_n, div_start, !div_stat.busy, "divider restarted while busy")
endmodule

>>> tb/running_stat_normalizer_unit_test.sv
// testbench for the running mean/variance normalizer: directed and random items checked against a predictor
module running_stat_normalizer_unit_test;
	import rsn_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		logic signed [VAL_W-1:0] value;
		logic                    normalized;
	} norm_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [CFG_AW-1:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;

	rsn_sample_if sample_ch();
	rsn_result_if result_ch();

	running_stat_normalizer_unit u_top (
		.clk(clk), .arst_n(arst_n), .sample_ch(sample_ch), .result_ch(result_ch),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	always #5 clk = ~clk;

	// predictor state
	longint            mean_tab [DIMENSIONS];
	longint unsigned   var_tab [DIMENSIONS];
	longint unsigned   obs_count;
	logic              norm_en;

	norm_result_t expected_results[$];
	int  errors = 0;
	int  items_sent = 0;
	int  normalized_seen = 0;
	int  results_seen = 0;
	bit  quiet = 0;
	int  ready_hold = 0;
	logic signed [VAL_W-1:0] center [DIMENSIONS];

	function automatic longint unsigned isqrt64(longint unsigned v);
		longint unsigned r;
		longint unsigned b;
		r = 0;
		b = 64'h4000_0000_0000_0000;
		while (b > v)
			b >>= 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	// welford update of one dimension
	function automatic void fold_into_stats(int d, longint x);
		longint n, m, delta, mnew, after;
		longint unsigned ma, mb, term, v, vnew;
		n = longint'(obs_count);
		m = mean_tab[d];
		delta = x - m;
		mnew = m + delta / n;
		after = x - mnew;
		ma = (delta < 0) ? -delta : delta;
		mb = (after < 0) ? -after : after;
		term = (ma * mb) >> 16;
		v = var_tab[d];
		if (term >= v)
			vnew = v + (term - v) / longint'(obs_count);
		else
			vnew = v - (v - term) / longint'(obs_count);
		if (vnew > 64'(VAR_MAX))
			vnew = 64'(VAR_MAX);
		mean_tab[d] = mnew;
		var_tab[d] = vnew;
	endfunction

	function automatic norm_result_t normalize_predict(logic signed [VAL_W-1:0] sv,
			int d, bit upd);
		norm_result_t r;
		longint x, num, q;
		longint unsigned v, sd;
		x = longint'(sv);
		r.value = sv;
		r.normalized = 1'b0;
		if (d >= DIMENSIONS)
			return r;
		if (norm_en && upd) begin
			if (d == 0 && obs_count != 64'(COUNT_MAX))
				obs_count++;
			if (obs_count != 0)
				fold_into_stats(d, x);
		end
		if (norm_en && obs_count > 1) begin
			v = var_tab[d];
			if (v < 1)
				v = 1;
			sd = isqrt64(v << 16);
			num = (x - mean_tab[d]) * 65536;
			q = num / longint'(sd);
			if (q > CLAMP_Q)
				q = CLAMP_Q;
			if (q < -CLAMP_Q)
				q = -CLAMP_Q;
			r.value = q[VAL_W-1:0];
			r.normalized = 1'b1;
		end
		return r;
	endfunction

	// result side: check each item and stall at random
	always @(posedge clk) begin
		norm_result_t e;
		if (result_ch.valid && result_ch.ready) begin
			results_seen++;
			if (result_ch.was_normalized)
				normalized_seen++;
			if (expected_results.size() == 0) begin
				errors++;
				$display("%0t: unexpected result value=%h norm=%b", $time,
					result_ch.result_value, result_ch.was_normalized);
			end else begin
				e = expected_results.pop_front();
				if (result_ch.result_value !== e.value) begin
					errors++;
					$display("%0t: result_value expected %h actual %h", $time,
						e.value, result_ch.result_value);
				end
				if (result_ch.was_normalized !== e.normalized) begin
					errors++;
					$display("%0t: was_normalized expected %b actual %b", $time,
						e.normalized, result_ch.was_normalized);
				end
			end
		end
		if (!arst_n || quiet) begin
			result_ch.ready <= 1'b1;
		end else if (ready_hold > 0) begin
			ready_hold <= ready_hold - 1;
			result_ch.ready <= 1'b0;
		end else if ($urandom_range(0, 9) == 0) begin
			ready_hold <= $urandom_range(1, 16) - 1;
			result_ch.ready <= 1'b0;
		end else begin
			result_ch.ready <= 1'b1;
		end
	end

	// send one item, predict it on acceptance, then maybe idle
	task automatic send_sample(logic signed [VAL_W-1:0] v, int d, bit upd);
		sample_ch.valid <= 1'b1;
		sample_ch.sample_value <= v;
		sample_ch.dimension <= d[DIM_W-1:0];
		sample_ch.update_stats <= upd;
		do @(posedge clk); while (!sample_ch.ready);
		expected_results.insert(expected_results.size(), normalize_predict(v, d, upd));
		items_sent++;
		if (!quiet && $urandom_range(0, 7) == 0) begin
			sample_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 16)) @(posedge clk);
		end
	endtask

	// stop sending and wait until every result has come back
	task automatic drain();
		sample_ch.valid <= 1'b0;
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_enable(bit en);
		psel <= 1'b1;
		pwrite <= 1'b1;
		penable <= 1'b0;
		paddr <= ADDR_NORM_EN;
		pwdata <= {31'd0, en};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		norm_en = en;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
	endtask

	task automatic read_enable();
		psel <= 1'b1;
		pwrite <= 1'b0;
		penable <= 1'b0;
		paddr <= ADDR_NORM_EN;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		if (prdata[0] !== norm_en) begin
			errors++;
			$display("%0t: normalize_enable readback expected %b actual %b", $time,
				norm_en, prdata[0]);
		end
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	function automatic logic signed [VAL_W-1:0] pick_value(int d);
		case ($urandom_range(0, 9))
			0, 1: return $urandom();
			2: return ($urandom_range(0, 1)) ? 32'sh7fff_ffff : 32'sh8000_0000;
			default: return center[d] + $signed($urandom_range(0, 32'h0004_0000))
				- 32'sh0002_0000;
		endcase
	endfunction

	// extremes, the zero-count case and first normalizations
	task automatic test_directed();
		read_enable();
		send_sample(32'sh0001_0000, 5, 1'b1);
		send_sample(32'sh0003_0000, 63, 1'b1);
		send_sample(32'sh7fff_ffff, 0, 1'b0);
		send_sample(32'sh0000_0000, 0, 1'b1);
		send_sample(32'sh8000_0000, 5, 1'b1);
		send_sample(32'sh0002_0000, 0, 1'b1);
		send_sample(32'sh7fff_ffff, 0, 1'b1);
		send_sample(32'sh8000_0000, 0, 1'b1);
		send_sample(32'sh8000_0000, 63, 1'b1);
		send_sample(32'sh7fff_ffff, 63, 1'b1);
		send_sample(32'sh0000_0000, 63, 1'b0);
		send_sample(32'shffff_ffff, 1, 1'b1);
		send_sample(32'shffff_ffff, 1, 1'b1);
		send_sample(32'sh0000_0001, 1, 1'b0);
		send_sample(32'sh5555_5555, 42, 1'b1);
		send_sample(32'shaaaa_aaaa, 21, 1'b1);
		send_sample(32'sh7fff_ffff, 21, 1'b0);
		send_sample(32'sh8000_0000, 42, 1'b0);
		drain();
	endtask

	// enable off: passthrough and statistics frozen, then back on
	task automatic test_enable_toggle();
		write_enable(1'b0);
		read_enable();
		for (int i = 0; i < 20; i++)
			send_sample($urandom(), $urandom_range(0, 63), 1'($urandom_range(0, 1)));
		drain();
		write_enable(1'b1);
		read_enable();
		for (int i = 0; i < 10; i++)
			send_sample(pick_value(i), i, 1'b1);
		drain();
	endtask

	// observation vectors with random content plus noise items
	task automatic test_random(int total);
		int sent;
		int len;
		sent = 0;
		while (sent < total) begin
			if (sent > total - 150)
				quiet = 1;
			if ($urandom_range(0, 4) != 0) begin
				len = $urandom_range(1, 8);
				if ($urandom_range(0, 15) == 0)
					len = 64;
				for (int d = 0; d < len; d++)
					send_sample(pick_value(d), d, $urandom_range(0, 9) != 0);
				sent += len;
			end else begin
				send_sample(pick_value(0), $urandom_range(0, 63),
					1'($urandom_range(0, 1)));
				sent++;
			end
			if (!quiet && $urandom_range(0, 60) == 0) begin
				drain();
				write_enable($urandom_range(0, 3) != 0);
			end
		end
		drain();
		write_enable(1'b1);
		read_enable();
	endtask

	initial begin
		for (int d = 0; d < DIMENSIONS; d++) begin
			mean_tab[d] = 0;
			var_tab[d] = 64'(VAR_RESET);
			center[d] = $urandom_range(0, 32'h0020_0000) - 32'sh0010_0000;
		end
		obs_count = 0;
		norm_en = 1'b1;
		sample_ch.valid = 1'b0;
		sample_ch.sample_value = '0;
		sample_ch.dimension = '0;
		sample_ch.update_stats = 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_enable_toggle();
		test_random(1700);
		repeat (250) @(posedge clk);
		$display("covered %0d items, %0d results, %0d normalized, count %0d",
			items_sent, results_seen, normalized_seen, obs_count);
		$display("enable toggled between phases, both sides idled at random");
		if (errors == 0 && expected_results.size() == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

	initial begin
		#40ms;
		$display("FAIL");
		$finish;
	end
endmodule

>>> sim.f
+incdir+sv
sv/rsn_pkg.sv
sv/rsn_sample_if.sv
sv/rsn_result_if.sv
sv/rsn_ram.sv
sv/rsn_div.sv
sv/rsn_sqrt.sv
sv/running_stat_normalizer_unit.sv
tb/running_stat_normalizer_unit_test.sv
